// ===== hw/rtl/ppst_pkg.sv =====
// Shared types, constants and helpers for the patterned pen stamp block.
`timescale 1ns / 1ps
package ppst_pkg;

  localparam int MAX_PEN    = 8;
  localparam int COORD_BITS = 16;
  localparam int PEN_W      = 4;                  // width of a pen size register
  localparam int DIM_W      = $clog2(MAX_PEN);    // width of a size minus one
  localparam int PAT_BITS   = 64;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [DIM_W-1:0]             dim_t;
  typedef logic [COLOR_W-1:0]           color_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEN_IS_BOX   = 3'd0,
    REG_PEN_WIDTH    = 3'd1,
    REG_PEN_HEIGHT   = 3'd2,
    REG_FILL_PATTERN = 3'd3,
    REG_COLOR_A      = 3'd4,
    REG_COLOR_B      = 3'd5
  } cfg_idx_e;

  // Pen shape as seen by the front end.
  typedef struct packed {
    logic             is_box;
    logic [PEN_W-1:0] width;
    logic [PEN_W-1:0] height;
  } pen_cfg_t;

  // One stamp request: top-left corner and box size minus one on each axis.
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    dim_t   wm1;
    dim_t   hm1;
  } stamp_t;

  // Saturated pen size minus one; only meaningful for a size of one or more.
  function automatic dim_t pen_dm1(input logic [PEN_W-1:0] v);
    logic [PEN_W-1:0] s;
    s = (v > PEN_W'(MAX_PEN)) ? PEN_W'(MAX_PEN) : v;
    return DIM_W'(s - PEN_W'(1));
  endfunction

endpackage

// ===== hw/rtl/ppst_front.sv =====
// Front end: classify an incoming point and build its stamp request.
`timescale 1ns / 1ps
module ppst_front (
  input  logic              acc_i,
  input  ppst_pkg::coord_t  point_x_i,
  input  ppst_pkg::coord_t  point_y_i,
  input  ppst_pkg::pen_cfg_t pen_i,
  output logic              wr_o,
  output ppst_pkg::stamp_t  stamp_o
);
  import ppst_pkg::*;

  logic zero_size;
  dim_t wm1, hm1, xoff, yoff;

  always_comb begin
    // Drop a box stamp of zero width or height: it writes nothing.
    zero_size = pen_i.is_box && ((pen_i.width == '0) || (pen_i.height == '0));
    wm1  = pen_i.is_box ? pen_dm1(pen_i.width)  : '0;
    hm1  = pen_i.is_box ? pen_dm1(pen_i.height) : '0;
    // ceil(size/2) - 1 equals (size - 1) / 2
    xoff = wm1 >> 1;
    yoff = hm1 >> 1;
    stamp_o.x0  = point_x_i - coord_t'({{(COORD_BITS-DIM_W){1'b0}}, xoff});
    stamp_o.y0  = point_y_i - coord_t'({{(COORD_BITS-DIM_W){1'b0}}, yoff});
    stamp_o.wm1 = wm1;
    stamp_o.hm1 = hm1;
    wr_o        = acc_i && !zero_size;
  end

endmodule

// ===== hw/rtl/ppst_fifo.sv =====
// Short request queue between the front end and the pixel walker.
`timescale 1ns / 1ps
module ppst_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  ppst_pkg::stamp_t wdata_i,
  input  logic             rd_i,
  output ppst_pkg::stamp_t rdata_o,
  output logic             full_o,
  output logic             empty_o
);
  import ppst_pkg::*;

  stamp_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wptr_q, rptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_wr, do_rd;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= QPTR_W'(wptr_q + 1'b1);
      if (do_rd) rptr_q <= QPTR_W'(rptr_q + 1'b1);
      if (do_wr && !do_rd) cnt_q <= QCNT_W'(cnt_q + 1'b1);
      else if (do_rd && !do_wr) cnt_q <= QCNT_W'(cnt_q - 1'b1);
    end
  end

endmodule

// ===== hw/rtl/ppst_back.sv =====
// Back end: walk the pixels of each stamp request into an output register.
`timescale 1ns / 1ps
module ppst_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppst_pkg::stamp_t              head_i,
  input  logic                          head_empty_i,
  output logic                          head_pop_o,
  input  logic [ppst_pkg::PAT_BITS-1:0] pattern_i,
  input  ppst_pkg::color_t              color_a_i,
  input  ppst_pkg::color_t              color_b_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output ppst_pkg::coord_t              pixel_x_o,
  output ppst_pkg::coord_t              pixel_y_o,
  output ppst_pkg::color_t              pixel_color_o,
  output logic                          last_pixel_o
);
  import ppst_pkg::*;

  stamp_t cur_q;
  logic   busy_q, busy_d;
  dim_t   col_q, row_q;
  logic   ovalid_q;
  coord_t ox_q, oy_q;
  color_t ocolor_q;
  logic   olast_q;

  logic   adv, row_end, fin, load;
  coord_t px, py;

  always_comb begin
    adv     = busy_q && (!ovalid_q || pop_i);
    row_end = (col_q == cur_q.wm1);
    fin     = adv && row_end && (row_q == cur_q.hm1);
    load    = (!busy_q || fin) && !head_empty_i;
    busy_d  = load ? 1'b1 : (fin ? 1'b0 : busy_q);
    px = cur_q.x0 + coord_t'({{(COORD_BITS-DIM_W){1'b0}}, col_q});
    py = cur_q.y0 + coord_t'({{(COORD_BITS-DIM_W){1'b0}}, row_q});
  end

  assign head_pop_o    = load;
  assign empty_o       = !ovalid_q;
  assign pixel_x_o     = ox_q;
  assign pixel_y_o     = oy_q;
  assign pixel_color_o = ocolor_q;
  assign last_pixel_o  = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (load) begin
        col_q <= '0;
        row_q <= '0;
      end else if (adv) begin
        col_q <= row_end ? '0 : DIM_W'(col_q + 1'b1);
        if (row_end) row_q <= DIM_W'(row_q + 1'b1);
      end
      if (adv) ovalid_q <= 1'b1;
      else if (pop_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= head_i;
    if (adv) begin
      ox_q     <= px;
      oy_q     <= py;
      ocolor_q <= pattern_i[{py[2:0], px[2:0]}] ? color_b_i : color_a_i;
      olast_q  <= fin;
    end
  end

endmodule

// ===== hw/rtl/patterned_pen_stamp_top.sv =====
// Top level of the patterned pen stamp: config registers, front end, queue, walker.
`timescale 1ns / 1ps
// A point's first pixel goes via the request queue, stamp register and output register.
// Throughput: one pixel per cycle from the pixel walker while pop keeps up; a stamp has
//   width*height pixels (1 for a dot, up to 64 for an 8x8 box); stamps follow without a gap.
// Zero-size box stamps are dropped by the front end, though the point is still taken.
// Reset (async, active low) empties the queue and output register and restores the
//   pen to a 1x1 dot with zero pattern and colors.
module patterned_pen_stamp_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // point requests
  input  logic                            push,
  output logic                            full,
  input  ppst_pkg::coord_t                point_x_i,
  input  ppst_pkg::coord_t                point_y_i,
  // pixel writes
  output logic                            empty,
  input  logic                            pop,
  output ppst_pkg::coord_t                pixel_x_o,
  output ppst_pkg::coord_t                pixel_y_o,
  output ppst_pkg::color_t                pixel_color_o,
  output logic                            last_pixel_o,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [ppst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppst_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import ppst_pkg::*;

  pen_cfg_t              pen_q;
  logic [PAT_BITS-1:0]   pattern_q;
  color_t                color_a_q, color_b_q;

  logic   acc;
  logic   q_wr, q_rd, q_empty;
  stamp_t q_wdata, q_rdata;

  // Configuration registers; an index outside the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q.is_box  <= 1'b0;
      pen_q.width   <= PEN_W'(1);
      pen_q.height  <= PEN_W'(1);
      pattern_q     <= '0;
      color_a_q     <= '0;
      color_b_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_PEN_IS_BOX:   pen_q.is_box <= cfg_wdata_i[0];
        REG_PEN_WIDTH:    pen_q.width  <= cfg_wdata_i[PEN_W-1:0];
        REG_PEN_HEIGHT:   pen_q.height <= cfg_wdata_i[PEN_W-1:0];
        REG_FILL_PATTERN: pattern_q    <= cfg_wdata_i[PAT_BITS-1:0];
        REG_COLOR_A:      color_a_q    <= cfg_wdata_i[COLOR_W-1:0];
        REG_COLOR_B:      color_b_q    <= cfg_wdata_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a point whenever the request queue has room.
  assign acc = push && !full;

  ppst_front u_front (
    .acc_i     (acc),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .pen_i     (pen_q),
    .wr_o      (q_wr),
    .stamp_o   (q_wdata)
  );

  // Hold stamp requests while the walker is busy with an earlier one.
  ppst_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .full_o  (full),
    .empty_o (q_empty)
  );

  // Advance through the box one pixel per cycle while pop keeps up, row by row with x inner.
  ppst_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_rdata),
    .head_empty_i  (q_empty),
    .head_pop_o    (q_rd),
    .pattern_i     (pattern_q),
    .color_a_i     (color_a_q),
    .color_b_i     (color_b_q),
    .pop_i         (pop),
    .empty_o       (empty),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

// ===== hw/rtl/ppst_checker.sv =====
// Port-level checks for the patterned pen stamp, bound to the top level.
`timescale 1ns / 1ps
module ppst_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             empty,
  input logic             pop,
  input ppst_pkg::coord_t pixel_x_o,
  input ppst_pkg::coord_t pixel_y_o,
  input ppst_pkg::color_t pixel_color_o,
  input logic             last_pixel_o
);
  import ppst_pkg::*;

  // A clock edge in reset leaves no pixel write pending on the next edge.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result pending after reset");

  // A pixel write that is not taken stays in place.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(pixel_x_o) && $stable(pixel_y_o)
                          && $stable(pixel_color_o) && $stable(last_pixel_o)))
    else $error("stalled pixel write changed");

  // Inside a stamp the next pixel is one step right, or on the next row.
  a_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_pixel_o) ##1 !empty |->
      ((pixel_x_o == coord_t'($past(pixel_x_o) + 1'b1) && pixel_y_o == $past(pixel_y_o))
       || (pixel_y_o == coord_t'($past(pixel_y_o) + 1'b1))))
    else $error("pixel walk out of order");

endmodule

bind patterned_pen_stamp_top ppst_checker u_ppst_checker (.*);

// ===== dv/ppst_stamp_checker.sv =====
// Predicts the pixel writes of each accepted point and checks them against the block.
`timescale 1ns / 1ps
module ppst_stamp_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  input  logic                            full,
  input  ppst_pkg::coord_t                point_x_i,
  input  ppst_pkg::coord_t                point_y_i,
  input  logic                            empty,
  input  logic                            pop,
  input  ppst_pkg::coord_t                pixel_x_i,
  input  ppst_pkg::coord_t                pixel_y_i,
  input  ppst_pkg::color_t                pixel_color_i,
  input  logic                            last_pixel_i,
  input  logic                            cfg_we_i,
  input  logic [ppst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppst_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned                     mismatches_o,
  output int unsigned                     pending_o,
  output int unsigned                     points_o,
  output int unsigned                     pixels_o
);
  import ppst_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_wr_t;

  pixel_wr_t         expected_pixels[$];
  pixel_wr_t         want;
  logic              pen_box;
  logic [PEN_W-1:0]  pen_w;
  logic [PEN_W-1:0]  pen_h;
  logic [PAT_BITS-1:0] pattern;
  color_t            ink_a;
  color_t            ink_b;
  int unsigned       mismatches;
  int unsigned       points;
  int unsigned       pixels;

  // Pattern lookup uses the low three bits of each coordinate, negatives included.
  function automatic pixel_wr_t shade(input coord_t x, input coord_t y, input logic last);
    pixel_wr_t p;
    p.x     = x;
    p.y     = y;
    p.color = pattern[{y[2:0], x[2:0]}] ? ink_b : ink_a;
    p.last  = last;
    return p;
  endfunction

  task automatic stamp_pixels(input coord_t px, input coord_t py);
    int unsigned w;
    int unsigned h;
    coord_t      x0;
    coord_t      y0;
    if (!pen_box) begin
      expected_pixels.push_back(shade(px, py, 1'b1));
      return;
    end
    w = (pen_w > MAX_PEN) ? MAX_PEN : pen_w;
    h = (pen_h > MAX_PEN) ? MAX_PEN : pen_h;
    if (w == 0 || h == 0) return;
    // Corner sits ceil(size/2)-1 up and left of the point; wrap at 16 bits.
    x0 = px - coord_t'((w + 1) / 2 - 1);
    y0 = py - coord_t'((h + 1) / 2 - 1);
    for (int unsigned i = 0; i < h; i++)
      for (int unsigned j = 0; j < w; j++)
        expected_pixels.push_back(shade(coord_t'(x0 + j), coord_t'(y0 + i),
                                        (i == h - 1) && (j == w - 1)));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_pixels.delete();
      pen_box    = 1'b0;
      pen_w      = PEN_W'(1);
      pen_h      = PEN_W'(1);
      pattern    = '0;
      ink_a      = '0;
      ink_b      = '0;
      mismatches = 0;
      points     = 0;
      pixels     = 0;
    end else begin
      if (pop && !empty) begin
        pixels++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pixel write: x=%0d y=%0d color=%h last=%b",
                     pixel_x_i, pixel_y_i, pixel_color_i, last_pixel_i);
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_x_i !== want.x || pixel_y_i !== want.y ||
              pixel_color_i !== want.color || last_pixel_i !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"pixel mismatch: expected x=%0d y=%0d color=%h last=%b,",
                        " got x=%0d y=%0d color=%h last=%b"},
                       want.x, want.y, want.color, want.last,
                       pixel_x_i, pixel_y_i, pixel_color_i, last_pixel_i);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PEN_IS_BOX:   pen_box = cfg_wdata_i[0];
          REG_PEN_WIDTH:    pen_w   = cfg_wdata_i[PEN_W-1:0];
          REG_PEN_HEIGHT:   pen_h   = cfg_wdata_i[PEN_W-1:0];
          REG_FILL_PATTERN: pattern = cfg_wdata_i[PAT_BITS-1:0];
          REG_COLOR_A:      ink_a   = cfg_wdata_i[COLOR_W-1:0];
          REG_COLOR_B:      ink_b   = cfg_wdata_i[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        points++;
        stamp_pixels(point_x_i, point_y_i);
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= expected_pixels.size();
    points_o     <= points;
    pixels_o     <= pixels;
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the patterned pen stamp: stimulus, register setup and verdict.
`timescale 1ns / 1ps
module tb;
  import ppst_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned RANDOM_POINTS    = 310;
  localparam int unsigned POINTS_PER_PHASE = 31;
  // Leave margin after the last pixel for dropped stamps.
  localparam int unsigned SETTLE_CYCLES    = 6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic [PAT_BITS-1:0]  PAT_ONES    = '1;
  localparam color_t               COLOR_ONES  = '1;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  push      = 1'b0;
  logic                  pop       = 1'b0;
  coord_t                point_x   = '0;
  coord_t                point_y   = '0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  no_idle   = 1'b0;
  logic                  full;
  logic                  empty;
  coord_t                pixel_x;
  coord_t                pixel_y;
  color_t                pixel_color;
  logic                  last_pixel;
  int unsigned           mismatches;
  int unsigned           pending;
  int unsigned           points;
  int unsigned           pixels;
  int unsigned           settings  = 0;
  int unsigned           cycles    = 0;

  patterned_pen_stamp_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push          (push),
    .full          (full),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .empty         (empty),
    .pop           (pop),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_color_o (pixel_color),
    .last_pixel_o  (last_pixel),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  ppst_stamp_checker pixel_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push          (push),
    .full          (full),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .empty         (empty),
    .pop           (pop),
    .pixel_x_i     (pixel_x),
    .pixel_y_i     (pixel_y),
    .pixel_color_i (pixel_color),
    .last_pixel_i  (last_pixel),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .points_o      (points),
    .pixels_o      (pixels)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold pop low with a chance of 37 in 100, never while no_idle is set.
  always @(posedge clk) pop <= no_idle || ($urandom_range(0, 99) >= 37);

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // One register write per cycle; the caller or set_pen drops the enable afterward.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write every register; fill unused upper data bits with noise, which must be dropped.
  // With spare set, also hit both unmapped indexes, which must change nothing.
  task automatic set_pen(input logic box, input logic [PEN_W-1:0] w, input logic [PEN_W-1:0] h,
                         input logic [PAT_BITS-1:0] pat, input color_t a, input color_t b,
                         input logic spare);
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_PEN_IS_BOX, {junk[CFG_DATA_W-1:1], box});
    write_reg(REG_PEN_WIDTH, {junk[CFG_DATA_W-1:PEN_W], w});
    write_reg(REG_PEN_HEIGHT, {~junk[CFG_DATA_W-1:PEN_W], h});
    write_reg(REG_FILL_PATTERN, pat);
    write_reg(REG_COLOR_A, {junk[CFG_DATA_W-1:COLOR_W], a});
    write_reg(REG_COLOR_B, {~junk[CFG_DATA_W-1:COLOR_W], b});
    if (spare) begin
      write_reg(REG_SPARE_6, '1);
      write_reg(REG_SPARE_7, junk);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Offer one point request; keep offering it while full is high.
  task automatic send_point(input coord_t x, input coord_t y);
    while (!no_idle && $urandom_range(0, 99) < 37) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    point_x <= x;
    point_y <= y;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Drop push, wait for every predicted pixel, then let a dropped stamp clear the pipe.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0 || !empty) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly uniform; one in eight lands on the 16-bit wrap point.
  function automatic coord_t rand_coord();
    if ($urandom_range(0, 7) == 0) return coord_t'(16'h7FF8 + $urandom_range(0, 15));
    return coord_t'($urandom);
  endfunction

  // Mostly legal sizes, some oversize (saturate to 8), rarely zero.
  function automatic logic [PEN_W-1:0] rand_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r <= 3) return PEN_W'($urandom_range(MAX_PEN + 1, 15));
    return PEN_W'($urandom_range(1, MAX_PEN));
  endfunction

  initial begin
    logic                box;
    logic [PEN_W-1:0]    w;
    logic [PEN_W-1:0]    h;
    logic [PAT_BITS-1:0] pat;
    logic                quiet;
    int unsigned         counted;
    int unsigned         phase;
    int unsigned         burst;
    counted = 0;
    phase   = 0;

    // Hold reset from time zero, then release it once for the whole run.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset pen: 1x1 dot, zero pattern and colors; drive the coordinate extremes.
    send_point(0, 0);
    send_point(-32768, 32767);
    send_point(32767, -32768);
    send_point(-1, -1);
    wait_idle();

    // Dot pen with zero sizes (sizes ignored); negative coordinates pick pattern bits.
    set_pen(1'b0, 4'd0, 4'd0, 64'h0123_4567_89AB_CDEF, 32'h1357_9BDF, COLOR_ONES, 1'b1);
    send_point(-1, -1);
    send_point(-8, -8);
    send_point(7, -2);
    send_point(-3, 5);
    wait_idle();

    // Full 8x8 box straddling the wrap on both axes.
    set_pen(1'b1, 4'd8, 4'd8, PAT_ONES, '0, COLOR_ONES, 1'b0);
    send_point(-32768, -32768);
    send_point(32767, 32767);
    wait_idle();

    // Oversize pen saturates; zero pattern gives color_a everywhere.
    set_pen(1'b1, 4'd15, 4'd9, '0, COLOR_ONES, 32'h0F0F_0F0F, 1'b0);
    send_point(5, -5);
    wait_idle();

    // Zero width, then zero height: stamps produce no pixels.
    set_pen(1'b1, 4'd0, 4'd5, PAT_ONES, 32'h0000_0001, 32'h0000_0002, 1'b0);
    send_point(0, 0);
    send_point(-32768, 32767);
    wait_idle();
    set_pen(1'b1, 4'd3, 4'd0, PAT_ONES, 32'h0000_0003, 32'h0000_0004, 1'b0);
    send_point(10, 10);
    send_point(1, -1);
    wait_idle();

    // Small boxes, odd and even sizes.
    set_pen(1'b1, 4'd1, 4'd1, 64'hAAAA_AAAA_AAAA_AAAA, 32'h2468_ACE0, 32'h1234_5678, 1'b0);
    send_point(-32768, 0);
    send_point(1, 1);
    wait_idle();
    set_pen(1'b1, 4'd2, 4'd3, 64'h5555_5555_5555_5555, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(0, 0);
    send_point(-4, 7);
    wait_idle();
    set_pen(1'b1, 4'd7, 4'd4, 64'hF0F0_F0F0_0F0F_0F0F, 32'h0000_FFFF, 32'hFFFF_0000, 1'b0);
    send_point(100, -100);
    wait_idle();

    // Random phases: fresh pen each phase, then a burst of points. Phase 3 runs with
    // no stalls on either side. Zero-size pens get a short burst that does not count.
    while (counted < RANDOM_POINTS) begin
      no_idle <= (phase == 3);
      box = ($urandom_range(0, 3) != 0);
      w   = rand_size();
      h   = rand_size();
      case ($urandom_range(0, 5))
        0:       pat = '0;
        1:       pat = PAT_ONES;
        default: pat = {$urandom, $urandom};
      endcase
      set_pen(box, w, h, pat, $urandom, $urandom, $urandom_range(0, 3) == 0);
      quiet = box && (w == 0 || h == 0);
      burst = quiet ? 3 : POINTS_PER_PHASE;
      for (int unsigned k = 0; k < burst; k++) begin
        send_point(rand_coord(), rand_coord());
        if (!quiet) counted++;
      end
      // Pause the sender until every predicted pixel has come back.
      wait_idle();
      phase++;
    end

    $display("Run covered %0d points over %0d pen settings: dot, box, oversize, zero-size, wrap",
             points, settings);
    $display("Checked %0d pixel writes, %0d mismatches", pixels, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
